FILE: rtl/idtp_pkg.sv
// Shared types, codes and helper functions of the ID3v2 tag frame parser.
`timescale 1ns / 1ps
`default_nettype none

package idtp_pkg;

  // Result event codes
  localparam logic [2:0] EV_TAG_START = 3'd0;
  localparam logic [2:0] EV_VALUE     = 3'd1;
  localparam logic [2:0] EV_EMPTY     = 3'd2;
  localparam logic [2:0] EV_BAD_MARK  = 3'd3;
  localparam logic [2:0] EV_BAD_ID    = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE_SYNCSAFE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_PICTURE_FRAMES = 1'd1;

  // Picture frame ID "APIC"
  localparam logic [31:0] ID_APIC = 32'h4150_4943;

  // Input item after classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_stream;
    logic       alnum;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] frame_id;
    logic [7:0]  value_byte;
    logic        last_in_frame;
    logic        last_in_tag;
  } result_t;

  // Expected byte of the "ID3" mark at a given position
  function automatic logic [7:0] mark_byte(input logic [1:0] pos);
    logic [7:0] m;
    unique case (pos)
      2'd0:    m = 8'h49;
      2'd1:    m = 8'h44;
      2'd2:    m = 8'h33;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // ASCII letter or digit
  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/idtp_queue.sv
// Small first-in first-out queue of items of a given type.
`timescale 1ns / 1ps
`default_nettype none

module idtp_queue #(
  parameter int  DEPTH  = 4,
  parameter type item_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      rd_item,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/idtp_front.sv
// Front end: accepts file bytes and classifies them for the parser queue.
`timescale 1ns / 1ps
`default_nettype none

module idtp_front (
  input  wire logic       push,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_stream,
  output logic            full,
  output logic            q_push,
  output idtp_pkg::in_item_t q_item,
  input  wire logic       q_full
);

  // Pass backpressure straight to the byte source
  assign full   = q_full;
  assign q_push = push && !q_full;

  // Tag each byte with its character class
  always_comb begin
    q_item.data_byte  = data_byte;
    q_item.new_stream = new_stream;
    q_item.alnum      = idtp_pkg::is_alnum(data_byte);
  end

endmodule

`default_nettype wire

FILE: rtl/idtp_back.sv
// Back end: tag and frame state machine, one classified byte per step.
`timescale 1ns / 1ps
`default_nettype none

module idtp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [idtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [0:0]             cfg_data,
  input  wire idtp_pkg::in_item_t     in_item,
  input  wire logic                   in_empty,
  output logic                        in_pop,
  output logic                        res_push,
  output idtp_pkg::result_t           res_item,
  input  wire logic                   res_full
);

  typedef enum logic [3:0] {
    PH_MARK, PH_HDR, PH_TSIZE, PH_FID, PH_FSIZE, PH_FFLAG, PH_VALUE, PH_DONE, PH_ERROR
  } phase_t;

  logic        frame_size_syncsafe;
  logic        drop_picture_frames;

  phase_t      phase, phase_c, phase_next;
  logic [2:0]  fbc, fbc_c, fbc_next;
  logic [27:0] tag_size, tag_size_c, tag_size_next;
  logic [31:0] bytes_consumed, bc_c, bytes_consumed_next;
  logic [31:0] frame_id, id_c, frame_id_next;
  logic [31:0] acc, acc_c, acc_next;
  logic [31:0] frame_remaining, rem_c, frame_remaining_next;
  logic        suppress, sup_c, suppress_next;
  logic        id_ok, id_ok_c, id_ok_next;

  logic        step;
  logic        res_valid;
  logic [7:0]  b;
  logic [31:0] bc_inc;
  logic        tag_end;
  logic [2:0]  fbc_inc;

  assign step     = !in_empty && !res_full;
  assign in_pop   = step;
  assign res_push = step && res_valid;
  assign b        = in_item.data_byte;

  // Start from cleared state on the first byte of a new stream
  always_comb begin
    if (in_item.new_stream) begin
      phase_c = PH_MARK;
      fbc_c   = '0;
      tag_size_c = '0;
      bc_c    = '0;
      id_c    = '0;
      acc_c   = '0;
      rem_c   = '0;
      sup_c   = 1'b0;
      id_ok_c = 1'b0;
    end else begin
      phase_c = phase;
      fbc_c   = fbc;
      tag_size_c = tag_size;
      bc_c    = bytes_consumed;
      id_c    = frame_id;
      acc_c   = acc;
      rem_c   = frame_remaining;
      sup_c   = suppress;
      id_ok_c = id_ok;
    end
  end

  // Saturating byte count and end-of-tag test on the updated count
  assign bc_inc  = (bc_c == '1) ? bc_c : bc_c + 32'd1;
  assign tag_end = (bc_inc >= {4'd0, tag_size_c});
  assign fbc_inc = fbc_c + 3'd1;

  // Decode one byte
  always_comb begin
    phase_next           = phase_c;
    fbc_next             = fbc_c;
    tag_size_next        = tag_size_c;
    bytes_consumed_next  = bc_c;
    frame_id_next        = id_c;
    acc_next             = acc_c;
    frame_remaining_next = rem_c;
    suppress_next        = sup_c;
    id_ok_next           = id_ok_c;
    res_valid            = 1'b0;
    res_item             = '0;
    unique case (phase_c)
      PH_MARK: begin
        if (b != idtp_pkg::mark_byte(fbc_c[1:0])) begin
          phase_next         = PH_ERROR;
          res_valid          = 1'b1;
          res_item.event_res = idtp_pkg::EV_BAD_MARK;
        end else begin
          fbc_next = fbc_inc;
          if (fbc_inc >= 3'd3) begin
            phase_next         = PH_HDR;
            fbc_next           = '0;
            acc_next           = '0;
            res_valid          = 1'b1;
            res_item.event_res = idtp_pkg::EV_TAG_START;
          end
        end
      end
      PH_HDR: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= 3'd3) begin
          phase_next = PH_TSIZE;
          fbc_next   = '0;
          acc_next   = '0;
        end
      end
      PH_TSIZE: begin
        acc_next = {4'd0, acc_c[20:0], b[6:0]};
        fbc_next = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          tag_size_next       = acc_next[27:0];
          bytes_consumed_next = '0;
          if (acc_next[27:0] == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_FID;
            fbc_next   = '0;
            acc_next   = '0;
          end
        end
      end
      PH_FID: begin
        bytes_consumed_next = bc_inc;
        frame_id_next       = {id_c[23:0], b};
        id_ok_next          = (fbc_c == '0) ? in_item.alnum : (id_ok_c && in_item.alnum);
        fbc_next            = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          if (!id_ok_next) begin
            phase_next         = PH_ERROR;
            res_valid          = 1'b1;
            res_item.event_res = idtp_pkg::EV_BAD_ID;
            res_item.frame_id  = frame_id_next;
          end else begin
            suppress_next = drop_picture_frames && (frame_id_next == idtp_pkg::ID_APIC);
            phase_next    = PH_FSIZE;
            fbc_next      = '0;
            acc_next      = '0;
          end
        end
      end
      PH_FSIZE: begin
        bytes_consumed_next = bc_inc;
        acc_next = frame_size_syncsafe ? {4'd0, acc_c[20:0], b[6:0]} : {acc_c[23:0], b};
        fbc_next = fbc_inc;
        if (fbc_inc >= 3'd4) begin
          frame_remaining_next = acc_next;
          phase_next           = PH_FFLAG;
          fbc_next             = '0;
          acc_next             = '0;
        end
      end
      PH_FFLAG: begin
        bytes_consumed_next = bc_inc;
        fbc_next            = fbc_inc;
        if (fbc_inc >= 3'd2) begin
          fbc_next = '0;
          acc_next = '0;
          if (rem_c == '0) begin
            phase_next = tag_end ? PH_DONE : PH_FID;
            if (!sup_c) begin
              res_valid              = 1'b1;
              res_item.event_res     = idtp_pkg::EV_EMPTY;
              res_item.frame_id      = id_c;
              res_item.last_in_frame = 1'b1;
              res_item.last_in_tag   = tag_end;
            end
          end else begin
            phase_next = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        bytes_consumed_next  = bc_inc;
        frame_remaining_next = rem_c - 32'd1;
        res_valid            = !sup_c;
        res_item.event_res   = idtp_pkg::EV_VALUE;
        res_item.frame_id    = id_c;
        res_item.value_byte  = b;
        if (rem_c == 32'd1) begin
          phase_next             = tag_end ? PH_DONE : PH_FID;
          fbc_next               = '0;
          acc_next               = '0;
          res_item.last_in_frame = 1'b1;
          res_item.last_in_tag   = tag_end;
        end
      end
      PH_DONE, PH_ERROR: begin
        // drop bytes until a new stream starts
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Hold configuration and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size_syncsafe <= 1'b1;
      drop_picture_frames <= 1'b1;
      phase           <= PH_MARK;
      fbc             <= '0;
      tag_size        <= '0;
      bytes_consumed  <= '0;
      frame_id        <= '0;
      acc             <= '0;
      frame_remaining <= '0;
      suppress        <= 1'b0;
      id_ok           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          idtp_pkg::REG_FRAME_SIZE_SYNCSAFE: frame_size_syncsafe <= cfg_data[0];
          idtp_pkg::REG_DROP_PICTURE_FRAMES: drop_picture_frames <= cfg_data[0];
          default: ;
        endcase
      end
      if (step) begin
        phase           <= phase_next;
        fbc             <= fbc_next;
        tag_size        <= tag_size_next;
        bytes_consumed  <= bytes_consumed_next;
        frame_id        <= frame_id_next;
        acc             <= acc_next;
        frame_remaining <= frame_remaining_next;
        suppress        <= suppress_next;
        id_ok           <= id_ok_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/id3v2_tag_frame_parser_top.sv
// Top level of the ID3v2 tag frame parser: front end, queues and back end.
// Usage:
//   Bytes of a file enter on data_byte with new_stream high on the first byte
//   of each file. A byte is taken at a clock edge with push high and full low.
//   Results leave from a queue: while empty is low the oldest result sits on
//   event_res, frame_id, value_byte, last_in_frame and last_in_tag, and pop at
//   a clock edge with empty low removes it.
//   Configuration registers are written through cfg_valid / cfg_index /
//   cfg_data; cfg_ready is always high and a write is registered at the clock edge.
//   A byte taken is written into the byte queue; the back end decodes it from
//   there and writes its result, if any, into the result queue for pop.
//   Throughput: one byte per cycle while the result queue has room; the parser
//   step in the back end and the one-entry-per-cycle queues set this figure.
//   Reset (rst, synchronous) empties both queues, returns the parser to the
//   mark search and sets both configuration registers to 1.
//   A stalled receiver fills the result queue; the back end then holds, the
//   byte queue fills, and full rises until pop frees room.
`timescale 1ns / 1ps
`default_nettype none

module id3v2_tag_frame_parser_top #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_stream,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       event_res,
  output logic [31:0]      frame_id,
  output logic [7:0]       value_byte,
  output logic             last_in_frame,
  output logic             last_in_tag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [idtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [0:0]  cfg_data
);

  logic                 in_q_push;
  logic                 in_q_full;
  logic                 in_q_empty;
  logic                 in_q_pop;
  idtp_pkg::in_item_t   in_q_wr;
  idtp_pkg::in_item_t   in_q_rd;
  logic                 res_push;
  logic                 res_full;
  idtp_pkg::result_t    res_wr;
  idtp_pkg::result_t    res_rd;

  assign cfg_ready = 1'b1;

  // Accept and classify bytes
  idtp_front u_front (
    .push       (push),
    .data_byte  (data_byte),
    .new_stream (new_stream),
    .full       (full),
    .q_push     (in_q_push),
    .q_item     (in_q_wr),
    .q_full     (in_q_full)
  );

  // Buffer classified bytes between front and back
  idtp_queue #(
    .DEPTH  (IN_DEPTH),
    .item_t (idtp_pkg::in_item_t)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .push    (in_q_push),
    .wr_item (in_q_wr),
    .full    (in_q_full),
    .pop     (in_q_pop),
    .rd_item (in_q_rd),
    .empty   (in_q_empty)
  );

  // Parse tag and frames
  idtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_q_rd),
    .in_empty  (in_q_empty),
    .in_pop    (in_q_pop),
    .res_push  (res_push),
    .res_item  (res_wr),
    .res_full  (res_full)
  );

  // Hold results for the receiver
  idtp_queue #(
    .DEPTH  (OUT_DEPTH),
    .item_t (idtp_pkg::result_t)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_item (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_item (res_rd),
    .empty   (empty)
  );

  assign event_res     = res_rd.event_res;
  assign frame_id      = res_rd.frame_id;
  assign value_byte    = res_rd.value_byte;
  assign last_in_frame = res_rd.last_in_frame;
  assign last_in_tag   = res_rd.last_in_tag;

endmodule

`default_nettype wire

FILE: bench/id3v2_tag_frame_parser_top_tb.sv
// Self-checking bench for the ID3v2 tag frame parser: streams random files, predicts each result.
`timescale 1ns / 1ps
`default_nettype none

module id3v2_tag_frame_parser_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [3:0] {
    P_MARK, P_HDR, P_TSIZE, P_FID, P_FSIZE, P_FFLAG, P_VALUE, P_DONE, P_ERROR
  } parse_phase_t;

  typedef struct {
    logic [7:0] b;
    logic       ns;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'h00;
  logic new_stream = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] event_res;
  logic [31:0] frame_id;
  logic [7:0] value_byte;
  logic last_in_frame;
  logic last_in_tag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [idtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [0:0] cfg_data = 1'b0;

  id3v2_tag_frame_parser_top i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .new_stream(new_stream),
    .empty(empty), .pop(pop),
    .event_res(event_res), .frame_id(frame_id), .value_byte(value_byte),
    .last_in_frame(last_in_frame), .last_in_tag(last_in_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Byte stream waiting to be pushed and results still owed by the block
  file_byte_t pending_bytes[$];
  idtp_pkg::result_t expected_events[$];
  int unsigned gen_count = 0;
  int unsigned mismatches = 0;
  int in_pct = 0;
  int out_pct = 0;
  bit in_fire = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned idle_cycles = 0;
  string ID_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

  // Parser state mirror and register copies
  logic cfg_ss = 1'b1;
  logic cfg_drop = 1'b1;
  parse_phase_t ph;
  logic [2:0] fcount;
  logic [27:0] tsize;
  logic [31:0] consumed;
  logic [31:0] cur_id;
  logic [31:0] acc;
  logic [31:0] remain;
  logic suppress;

  logic [7:0] directed_bytes [34] = '{
    8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h80, 8'h80, 8'h00, 8'h95,
    8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'hff,
    8'h54, 8'h58, 8'h58, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff,
    8'h49, 8'h58, 8'h00
  };

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_id_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic int unsigned idle_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function void clear_parser();
    ph = P_MARK;
    fcount = '0;
    tsize = '0;
    consumed = '0;
    cur_id = '0;
    acc = '0;
    remain = '0;
    suppress = 1'b0;
  endfunction

  function void start_field(input parse_phase_t p);
    ph = p;
    fcount = '0;
    acc = '0;
  endfunction

  function void bump_consumed();
    if (consumed != 32'hffff_ffff) consumed++;
  endfunction

  function void close_frame();
    if (consumed >= {4'b0, tsize}) ph = P_DONE;
    else start_field(P_FID);
  endfunction

  // Advance the parser mirror by one byte and queue the result it owes
  function void parse_byte(input logic [7:0] b, input logic ns);
    idtp_pkg::result_t r;
    bit hit;
    r = '0;
    hit = 1'b0;
    if (ns) clear_parser();
    case (ph)
      P_MARK: begin
        if (b != 8'("ID3" >> (8 * (2 - fcount)))) begin
          ph = P_ERROR;
          r.event_res = idtp_pkg::EV_BAD_MARK;
          hit = 1'b1;
        end else begin
          fcount++;
          if (fcount == 3'd3) begin
            start_field(P_HDR);
            r.event_res = idtp_pkg::EV_TAG_START;
            hit = 1'b1;
          end
        end
      end
      P_HDR: begin
        fcount++;
        if (fcount == 3'd3) start_field(P_TSIZE);
      end
      P_TSIZE: begin
        acc = {4'b0, acc[20:0], b[6:0]};
        fcount++;
        if (fcount == 3'd4) begin
          tsize = acc[27:0];
          consumed = '0;
          if (tsize == '0) ph = P_DONE;
          else start_field(P_FID);
        end
      end
      P_FID: begin
        bump_consumed();
        cur_id = {cur_id[23:0], b};
        fcount++;
        if (fcount == 3'd4) begin
          if (!(is_id_char(cur_id[31:24]) && is_id_char(cur_id[23:16]) &&
                is_id_char(cur_id[15:8]) && is_id_char(cur_id[7:0]))) begin
            ph = P_ERROR;
            r.event_res = idtp_pkg::EV_BAD_ID;
            r.frame_id = cur_id;
            hit = 1'b1;
          end else begin
            suppress = cfg_drop && (cur_id == idtp_pkg::ID_APIC);
            start_field(P_FSIZE);
          end
        end
      end
      P_FSIZE: begin
        bump_consumed();
        if (cfg_ss) acc = {4'b0, acc[20:0], b[6:0]};
        else acc = {acc[23:0], b};
        fcount++;
        if (fcount == 3'd4) begin
          remain = acc;
          start_field(P_FFLAG);
        end
      end
      P_FFLAG: begin
        bump_consumed();
        fcount++;
        if (fcount == 3'd2) begin
          if (remain == '0) begin
            close_frame();
            r.event_res = idtp_pkg::EV_EMPTY;
            r.frame_id = cur_id;
            r.last_in_frame = 1'b1;
            r.last_in_tag = (ph == P_DONE);
            hit = !suppress;
          end else begin
            start_field(P_VALUE);
          end
        end
      end
      P_VALUE: begin
        bump_consumed();
        remain--;
        r.event_res = idtp_pkg::EV_VALUE;
        r.frame_id = cur_id;
        r.value_byte = b;
        if (remain == '0) begin
          close_frame();
          r.last_in_frame = 1'b1;
          r.last_in_tag = (ph == P_DONE);
        end
        hit = !suppress;
      end
      default: ;
    endcase
    if (hit) expected_events.insert(expected_events.size(), r);
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= 200) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // Sender: present the next item at the falling edge, with random gaps
  always @(negedge clk) begin : byte_driver
    file_byte_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        push <= 1'b1;
        data_byte <= nxt.b;
        new_stream <= nxt.ns;
        in_gap = idle_len(in_pct);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Take accepted items into the parser mirror
  always @(posedge clk) begin
    in_fire = !rst && push && !full;
    if (in_fire) parse_byte(data_byte, new_stream);
  end

  // Receiver: random stalls on pop
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      out_gap = idle_len(out_pct);
    end
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk) begin : result_check
    idtp_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (expected_events.size() == 0) begin
        report_error($sformatf("unexpected result: event %0d id %h value %h",
                               event_res, frame_id, value_byte));
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", 32'(event_res), 32'(want.event_res));
        check_field("frame_id", frame_id, want.frame_id);
        check_field("value_byte", 32'(value_byte), 32'(want.value_byte));
        check_field("last_in_frame", 32'(last_in_frame), 32'(want.last_in_frame));
        check_field("last_in_tag", 32'(last_in_tag), 32'(want.last_in_tag));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [idtp_pkg::CFG_IDX_W-1:0] idx, input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == idtp_pkg::REG_FRAME_SIZE_SYNCSAFE) cfg_ss = v;
    else cfg_drop = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pending byte is sent and every owed result has come out
  task automatic drain();
    while (pending_bytes.size() != 0 || push) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build one file: mostly well-formed tags, some broken, some noise
  task automatic gen_file();
    file_byte_t s[$];
    logic [7:0] body[$];
    logic [31:0] fid;
    logic [31:0] fsz;
    logic [31:0] tsz;
    logic [7:0] c;
    int unsigned kind, nfr, bad_fr, k, j, pick;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(12, 1))
        s.insert(s.size(), '{b: 8'($urandom_range(255)), ns: ($urandom_range(7) == 0)});
      s[0].ns = 1'b1;
    end else begin
      nfr = $urandom_range(4);
      bad_fr = (kind >= 12 && kind < 18 && nfr > 0) ? $urandom_range(nfr - 1) : 99;
      for (k = 0; k < nfr; k++) begin
        if ($urandom_range(5) == 0) begin
          fid = idtp_pkg::ID_APIC;
        end else begin
          for (j = 0; j < 4; j++) fid = {fid[23:0], ID_CHARS[$urandom_range(61)]};
        end
        if (k == bad_fr) begin
          do c = 8'($urandom_range(255)); while (is_id_char(c));
          fid[8 * $urandom_range(3) +: 8] = c;
        end
        fsz = ($urandom_range(9) == 0) ? $urandom_range(300, 7) : $urandom_range(6);
        for (j = 0; j < 4; j++) body.insert(body.size(), fid[8 * (3 - j) +: 8]);
        for (j = 0; j < 4; j++) begin
          if (cfg_ss)
            body.insert(body.size(), {($urandom_range(3) == 0), fsz[7 * (3 - j) +: 7]});
          else body.insert(body.size(), fsz[8 * (3 - j) +: 8]);
        end
        repeat (2) body.insert(body.size(), 8'($urandom_range(255)));
        repeat (fsz) body.insert(body.size(), 8'($urandom_range(255)));
      end
      // Tag size: exact, cut short, or longer with zero padding after the frames
      tsz = body.size();
      pick = $urandom_range(9);
      if (pick == 6) begin
        tsz = $urandom_range(tsz);
      end else if (pick >= 7) begin
        tsz = tsz + $urandom_range(20, 1);
        repeat ($urandom_range(6)) body.insert(body.size(), 8'h00);
      end else begin
        repeat ($urandom_range(3)) body.insert(body.size(), 8'($urandom_range(255)));
      end
      s.insert(s.size(), '{b: 8'h49, ns: 1'b1});
      s.insert(s.size(), '{b: 8'h44, ns: 1'b0});
      s.insert(s.size(), '{b: 8'h33, ns: 1'b0});
      repeat (3) s.insert(s.size(), '{b: 8'($urandom_range(255)), ns: 1'b0});
      for (j = 0; j < 4; j++)
        s.insert(s.size(), '{b: {($urandom_range(3) == 0), tsz[7 * (3 - j) +: 7]}, ns: 1'b0});
      foreach (body[i]) s.insert(s.size(), '{b: body[i], ns: 1'b0});
      // Break the mark or truncate the file
      if (kind >= 6 && kind < 12)
        s[$urandom_range(2)].b ^= 8'($urandom_range(255, 1));
      if (kind >= 18 && kind < 24)
        s = s[0:$urandom_range(s.size() - 1, 1) - 1];
    end
    foreach (s[i]) pending_bytes.insert(pending_bytes.size(), s[i]);
    gen_count += s.size();
  endtask

  task automatic run_phase(input logic ss, input logic drop, input int ipct,
                           input int opct, input int unsigned n);
    int unsigned target;
    drain();
    write_reg(idtp_pkg::REG_FRAME_SIZE_SYNCSAFE, ss);
    write_reg(idtp_pkg::REG_DROP_PICTURE_FRAMES, drop);
    in_pct = ipct;
    out_pct = opct;
    target = gen_count + n / 2;
    while (gen_count < target) gen_file();
    drain();
    target = gen_count + n - n / 2;
    while (gen_count < target) gen_file();
  endtask

  // Reset, directed files, then random phases over every register setting
  initial begin
    clear_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    in_pct = 20;
    out_pct = 20;
    foreach (directed_bytes[i])
      pending_bytes.insert(pending_bytes.size(),
                           '{b: directed_bytes[i], ns: (i == 0 || i == 31)});
    run_phase(1'b0, 1'b0, 0, 0, 490);
    run_phase(1'b1, 1'b0, 20, 20, 490);
    run_phase(1'b0, 1'b1, 50, 10, 490);
    run_phase(1'b1, 1'b1, 10, 50, 490);
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
